// ===== rtl/dtjs_pkg.sv =====
// shared types and constants for the dirty tile job scheduler
package dtjs_pkg;
  localparam int MaxTiles = 64;
  localparam int MaxJobs = 16;
  localparam int TileW = 6;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_MARK     = 3'd1,
    CMD_TAKE     = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_RETRY    = 3'd4
  } cmd_t;

  localparam logic [1:0] REG_TILE_COUNT = 2'd0;
  localparam logic [1:0] REG_SETTLE     = 2'd1;
  localparam logic [1:0] REG_JOB_LIMIT  = 2'd2;

  // settle check request
  typedef struct packed {
    logic [47:0] now;
    logic [47:0] changed;
    logic [31:0] delay;
  } settle_req_t;
endpackage

// ===== rtl/dtjs_settle.sv =====
// shared settle compare unit: now >= changed and now - changed >= delay
module dtjs_settle (
  input  dtjs_pkg::settle_req_t req,
  output logic                  ok
);
  import dtjs_pkg::*;
  logic [48:0] diff;
  assign diff = {1'b0, req.now} - {1'b0, req.changed};
  assign ok = !diff[48] && (diff[47:0] >= {16'd0, req.delay});
endmodule

// ===== rtl/dirty_tile_job_scheduler_top.sv =====
// Dirty tile job scheduler: per-tile revision, change time, dirty/busy flags and attempts.
// A command is one beat in (cmd on in_tuser, the rest on in_tdata). Every command gives one or
// more result beats: take gives one beat per issued job, or one beat with job_valid low when it
// issues none, and tlast marks the final beat. One command is worked on at a time and in_tready
// stays low until its last beat has been taken. Mark, complete, retry, an unknown command and
// a take that cannot issue pass through the read, exec and out states. Clear writes one
// revision per cycle over the active tiles. Take reads and checks one tile at a time, each in
// a scan and a check state, through a single tile memory port and one shared settle compare;
// each found job is held back until the next job or the end of the scan is known, so tlast
// lands on the final job. Output stalls delay every command. Revision, time and attempt
// memories hold their contents through reset; entries become valid through per-tile valid
// bits cleared by reset and clear.
module dirty_tile_job_scheduler_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tile[5:0], time_ms[53:6], revision[85:54], attempt[101:86]
  input  logic [103:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // job_tile[5:0], job_revision[37:6], job_attempt[53:38], accepted[54], bad_tile[55]
  output logic [55:0]  out_tdata,
  // job_valid[0]
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import dtjs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_CHECK = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r;
  logic [6:0]  tile_count_r;
  logic [31:0] settle_r;
  logic [4:0]  job_limit_r;

  logic [2:0]  cmd_r;
  logic [5:0]  tile_r;
  logic [47:0] now_r;
  logic [31:0] rev_r;
  logic [15:0] att_r;

  logic [31:0] rev_mem [MaxTiles];
  logic [47:0] time_mem [MaxTiles];
  logic [15:0] att_mem [MaxTiles];
  logic [MaxTiles-1:0] valid_r, dirty_r, busy_r;
  logic [31:0] rev_cnt_r;
  logic [5:0]  cursor_r;

  logic [31:0] rd_rev_r;
  logic [47:0] rd_time_r;
  logic [15:0] rd_att_r;
  logic [5:0]  rd_idx_r;

  logic [6:0]  n_act, visited_r;
  logic [4:0]  lim, issued_r;
  logic [5:0]  idx_r;

  logic [55:0] out_data_r;
  logic        out_last_r, out_valid_r, out_user_r;
  logic [55:0] pend_data_r;
  logic        pend_vld_r;

  assign n_act = (tile_count_r > 7'(MaxTiles)) ? 7'(MaxTiles) : tile_count_r;
  assign lim   = (job_limit_r > 5'(MaxJobs)) ? 5'(MaxJobs) : job_limit_r;

  // memory read with valid masking
  logic [31:0] e_rev;
  logic [15:0] e_att;
  assign e_rev = rd_rev_r;
  assign e_att = rd_att_r;

  settle_req_t sreq;
  logic settled;
  assign sreq.now = now_r;
  assign sreq.changed = rd_time_r;
  assign sreq.delay = settle_r;
  dtjs_settle u_settle (.req(sreq), .ok(settled));

  logic [5:0] rd_addr;
  assign rd_addr = (state_r == ST_IDLE) ? in_tdata[5:0] :
                   ((state_r == ST_SCAN || state_r == ST_CHECK) ? idx_r : tile_r);

  always_ff @(posedge clk) begin
    rd_rev_r  <= valid_r[rd_addr] ? rev_mem[rd_addr] : 32'd0;
    rd_time_r <= valid_r[rd_addr] ? time_mem[rd_addr] : 48'd0;
    rd_att_r  <= valid_r[rd_addr] ? att_mem[rd_addr] : 16'd0;
    rd_idx_r  <= rd_addr;
  end

  logic cur;
  assign cur = ({1'b0, tile_r} < n_act) && (e_rev == rev_r) && (e_att == att_r);
  logic [15:0] att_inc;
  assign att_inc = e_att + 16'd1;

  logic hit;
  logic [5:0] nxt;
  assign hit = dirty_r[rd_idx_r] && !busy_r[rd_idx_r] && settled;
  assign nxt = (({1'b0, rd_idx_r} + 7'd1) >= n_act) ? 6'd0 : rd_idx_r + 6'd1;

  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  function automatic logic [55:0] pack(logic [5:0] t, logic [31:0] r, logic [15:0] a,
                                       logic acc, logic bad);
    pack = {bad, acc, a, r, t};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tile_count_r <= '0; settle_r <= '0; job_limit_r <= 5'd1;
      valid_r <= '0; dirty_r <= '0; busy_r <= '0;
      rev_cnt_r <= '0; cursor_r <= '0;
      out_valid_r <= 1'b0; out_last_r <= 1'b0; out_data_r <= '0; out_user_r <= 1'b0;
      pend_vld_r <= 1'b0; pend_data_r <= '0;
      visited_r <= '0; issued_r <= '0; idx_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TILE_COUNT: tile_count_r <= cfg_wdata[6:0];
          REG_SETTLE:     settle_r <= cfg_wdata;
          REG_JOB_LIMIT:  job_limit_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          cmd_r <= in_tuser; tile_r <= in_tdata[5:0]; now_r <= in_tdata[53:6];
          rev_r <= in_tdata[85:54]; att_r <= in_tdata[101:86];
          state_r <= ST_READ;
        end
        ST_READ: state_r <= ST_EXEC;
        ST_EXEC: begin
          out_last_r <= 1'b1;
          out_data_r <= '0;
          out_user_r <= 1'b0;
          state_r <= ST_OUT;
          case (cmd_r)
            CMD_CLEAR: begin
              valid_r <= '0; dirty_r <= '0; busy_r <= '0;
              cursor_r <= '0; idx_r <= '0; visited_r <= '0;
              state_r <= (n_act == 7'd0) ? ST_OUT : ST_SCAN;
              out_valid_r <= (n_act == 7'd0);
            end
            CMD_MARK: begin
              out_valid_r <= 1'b1;
              if ({1'b0, tile_r} >= n_act) begin
                out_data_r <= pack(6'd0, 32'd0, 16'd0, 1'b0, 1'b1);
              end else begin
                rev_mem[tile_r] <= rev_cnt_r + 32'd1;
                rev_cnt_r <= rev_cnt_r + 32'd1;
                time_mem[tile_r] <= now_r;
                att_mem[tile_r] <= '0;
                valid_r[tile_r] <= 1'b1;
                dirty_r[tile_r] <= 1'b1; busy_r[tile_r] <= 1'b0;
              end
            end
            CMD_TAKE: begin
              if (n_act == 7'd0 || lim == 5'd0) out_valid_r <= 1'b1;
              else begin
                idx_r <= ({1'b0, cursor_r} >= n_act) ? 6'd0 : cursor_r;
                visited_r <= '0; issued_r <= '0;
                pend_vld_r <= 1'b0;
                state_r <= ST_SCAN;
              end
            end
            CMD_COMPLETE: begin
              out_valid_r <= 1'b1;
              if (cur && busy_r[tile_r]) begin
                dirty_r[tile_r] <= 1'b0; busy_r[tile_r] <= 1'b0;
                out_data_r <= pack(6'd0, 32'd0, 16'd0, 1'b1, 1'b0);
              end
            end
            CMD_RETRY: begin
              out_valid_r <= 1'b1;
              if (cur) begin
                busy_r[tile_r] <= 1'b0;
                time_mem[tile_r] <= now_r;
                // the entry may never have been written, keep its zero contents valid
                rev_mem[tile_r] <= e_rev;
                att_mem[tile_r] <= e_att;
                valid_r[tile_r] <= 1'b1;
                out_data_r <= pack(6'd0, 32'd0, 16'd0, 1'b1, 1'b0);
              end
            end
            default: out_valid_r <= 1'b1;
          endcase
        end
        ST_SCAN: begin
          if (cmd_r == CMD_CLEAR) begin
            rev_mem[idx_r] <= rev_cnt_r + 32'd1;
            rev_cnt_r <= rev_cnt_r + 32'd1;
            time_mem[idx_r] <= '0; att_mem[idx_r] <= '0;
            valid_r[idx_r] <= 1'b1;
            idx_r <= idx_r + 6'd1;
            if (visited_r + 7'd1 >= n_act) begin
              out_valid_r <= 1'b1; out_data_r <= '0; out_last_r <= 1'b1;
              state_r <= ST_OUT;
            end
            visited_r <= visited_r + 7'd1;
          end else state_r <= ST_CHECK;
        end
        ST_CHECK: if (!out_valid_r || out_tready) begin
          cursor_r <= nxt;
          idx_r <= nxt;
          visited_r <= visited_r + 7'd1;
          if (hit) begin
            busy_r[rd_idx_r] <= 1'b1;
            att_mem[rd_idx_r] <= att_inc;
            issued_r <= issued_r + 5'd1;
            // another job follows, so the held one goes out without tlast
            if (pend_vld_r) begin
              out_valid_r <= 1'b1; out_user_r <= 1'b1;
              out_data_r <= pend_data_r; out_last_r <= 1'b0;
            end
            pend_vld_r <= 1'b1;
            pend_data_r <= pack(rd_idx_r, e_rev, att_inc, 1'b0, 1'b0);
          end
          if ((hit && issued_r + 5'd1 >= lim) || visited_r + 7'd1 >= n_act) state_r <= ST_FIN;
          else state_r <= ST_SCAN;
        end
        ST_FIN: if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          out_user_r <= pend_vld_r;
          out_data_r <= pend_vld_r ? pend_data_r : '0;
          out_last_r <= 1'b1;
          pend_vld_r <= 1'b0;
          state_r <= ST_OUT;
        end
        ST_OUT: if (!out_valid_r || out_tready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("beat dropped");
  a_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (issued_r < lim)) else $error("too many jobs");
`endif
endmodule
